// ===== src/ppt_pkg.sv =====
// Shared types, constants and arithmetic helpers of the position and P&L tracker.
`default_nettype none
package ppt_pkg;

    localparam int DEF_ACCOUNTS = 16;
    localparam int DEF_SYMBOLS  = 256;

    localparam logic [15:0] EPS_RESET = 16'd7;

    localparam int NUM_W      = 89;
    localparam int DEN_W      = 49;
    localparam int MUL_DIGITS = 3;
    localparam int DIV_STEPS  = 40;
    localparam int CNT_W      = 6;

    localparam logic [1:0] FN_FILL   = 2'd0;
    localparam logic [1:0] FN_PRICE  = 2'd1;
    localparam logic [1:0] FN_CASH   = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    localparam logic [2:0] EV_OPENED    = 3'd0;
    localparam logic [2:0] EV_INCREASED = 3'd1;
    localparam logic [2:0] EV_DECREASED = 3'd2;
    localparam logic [2:0] EV_CLOSED    = 3'd3;
    localparam logic [2:0] EV_REVERSED  = 3'd4;
    localparam logic [2:0] EV_PRICE     = 3'd5;
    localparam logic [2:0] EV_CASH_SET  = 3'd6;
    localparam logic [2:0] EV_ABSENT    = 3'd7;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         account;
        logic [7:0]         symbol;
        logic signed [47:0] fill_quantity;
        logic [39:0]        price;
        logic [39:0]        commission;
        logic signed [63:0] cash_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic signed [47:0] position_size;
        logic [39:0]        entry_price;
        logic signed [63:0] unrealized;
        logic signed [63:0] realized;
        logic signed [63:0] total_profit;
        logic [62:0]        mkt_value;
        logic [62:0]        basis_value;
        logic signed [63:0] cash_after;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic signed [47:0] qty;
        logic [39:0]        avg;
        logic [39:0]        mkt;
        logic signed [63:0] pnl;
    } t_entry;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic             start;
        t_mdu_op          op;
        logic [NUM_W-1:0] a;
        logic [DEN_W-1:0] b;
    } t_mdu_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] res;
    } t_mdu_rsp;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_FILL,
        ST_AVG_MUL1,
        ST_AVG_MUL2,
        ST_AVG_DIV,
        ST_RPNL_MUL,
        ST_RPNL_ADD,
        ST_COST_MUL,
        ST_DEBIT,
        ST_CASH,
        ST_UNR_MUL,
        ST_MV_MUL,
        ST_CB_MUL,
        ST_WRITE,
        ST_OUT
    } t_state;

    function automatic logic [47:0] f_mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    // floor(+/- p / 2^16), saturated to signed 64 bits
    function automatic logic signed [63:0] f_qmul(input logic neg, input logic [87:0] p);
        logic [88:0] t;
        logic [72:0] s;
        logic signed [63:0] r;
        t = {1'b0, p} + (neg ? 89'h0FFFF : 89'h0);
        s = t[88:16];
        if (!neg) begin
            r = (s[72:63] != '0) ? S64_MAX : s[63:0];
        end else begin
            r = (s[72:63] != '0) ? S64_MIN : -s[63:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] f_sat_add(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] f_sat_sub(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/ppt_mdu.sv =====
// Shared iterative multiplier (16-bit digit per cycle) and restoring divider (bit per cycle).
`default_nettype none
module ppt_mdu
    import ppt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mdu_req i_req,
    output t_mdu_rsp      o_rsp
);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_mdu_op          r_op, n_op;
    logic [NUM_W-1:0] r_acc, n_acc;
    logic [39:0]      r_mc, n_mc;
    logic [47:0]      r_mp, n_mp;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [39:0]      r_num, n_num;
    logic [39:0]      r_quo, n_quo;

    logic [55:0]      prod;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic             last;

    assign prod  = r_mc * r_mp[47:32];
    assign trial = {r_rem, r_num[39]};
    assign ge    = trial >= {1'b0, r_den};
    assign last  = (r_op == MDU_MUL) ? (r_cnt == CNT_W'(MUL_DIGITS - 1))
                                     : (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        n_rem  = r_rem;
        n_den  = r_den;
        n_num  = r_num;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_op   = i_req.op;
            n_acc  = '0;
            n_mc   = i_req.a[39:0];
            n_mp   = i_req.b[47:0];
            n_rem  = i_req.a[NUM_W-1:40];
            n_den  = i_req.b;
            n_num  = i_req.a[39:0];
            n_quo  = '0;
        end else if (r_busy) begin
            if (r_op == MDU_MUL) begin
                // high digit first, shift the running sum up
                n_acc = {r_acc[NUM_W-17:0], 16'h0} + NUM_W'(prod);
                n_mp  = {r_mp[31:0], 16'h0};
            end else begin
                n_rem = ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                n_num = {r_num[38:0], 1'b0};
                n_quo = {r_quo[38:0], ge};
            end
            n_cnt = r_cnt + 1'b1;
            if (last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= MDU_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == MDU_MUL) ? r_acc : NUM_W'(r_quo);

endmodule
`default_nettype wire

// ===== src/position_pnl_tracker_top.sv =====
// Top level of the position and P&L tracker: sequencer, position memory and cash table.
`default_nettype none
// Keeps an average-cost position per (account, symbol) in a single-port memory of
// ACCOUNTS*SYMBOLS entries and a cash balance per account. One transaction is worked
// at a time; o_in_stall is high until its result is handed to the output register.
// Every product and the average-price division run through one shared iterative unit:
// a multiply works through three 16-bit digits, the division one quotient bit a cycle.
// A cash set or an out-of-range transaction goes straight to the output register; the
// others read their entry first. An unused function code or a price update on an absent
// entry then ends; a price update recomputes the unrealized P&L, market value and basis,
// and a fill does the same after updating the position, any realized P&L and the cash.
// After reset a clearing pass walks the memory one entry a cycle (ACCOUNTS*SYMBOLS
// entries, 4096 by default) before the first transaction is taken; configuration
// writes are taken at any time.
module position_pnl_tracker_top
    import ppt_pkg::*;
#(
    parameter int ACCOUNTS = DEF_ACCOUNTS,
    parameter int SYMBOLS  = DEF_SYMBOLS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out
);

    localparam int ENTRIES = ACCOUNTS * SYMBOLS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CLR_W   = $clog2(ENTRIES + 1);
    localparam int ACCT_W  = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;

    t_state r_state, n_state;

    logic [15:0]         r_eps;
    logic [CLR_W-1:0]    r_clr_cnt;
    logic                r_launched, n_launched;
    logic                r_out_valid;
    t_out_item           r_out;

    t_in_item            r_in, n_in;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [ACCT_W-1:0]   r_acct, n_acct;
    logic                r_blank, n_blank;
    logic [2:0]          r_kind, n_kind;
    logic signed [47:0]  r_q, n_q;
    logic [39:0]         r_avg, n_avg;
    logic [39:0]         r_mkt, n_mkt;
    logic signed [63:0]  r_pnl, n_pnl;
    logic signed [63:0]  r_cash, n_cash;
    logic [NUM_W-1:0]    r_acc, n_acc;
    logic signed [63:0]  r_cost, n_cost;
    logic signed [63:0]  r_unr, n_unr;
    logic signed [63:0]  r_tot, n_tot;
    logic [62:0]         r_mv, n_mv;
    logic [62:0]         r_cb, n_cb;

    t_entry              mem [ENTRIES];
    t_entry              r_rdata;
    logic [IDX_W-1:0]    mem_addr;
    logic                mem_we;
    t_entry              mem_wdata;

    logic signed [63:0]  r_cash_tab [ACCOUNTS];
    logic                cash_we;
    logic [ACCT_W-1:0]   cash_waddr;
    logic signed [63:0]  cash_wdata;

    t_mdu_req            mdu_req;
    t_mdu_rsp            mdu_rsp;

    logic                in_accept;
    logic                in_range;
    logic                out_load;
    logic                uses_mdu;
    logic signed [47:0]  fq;
    logic [47:0]         af, ao;
    logic                old_pos, old_neg, fq_pos, fq_neg;
    logic                flat_old, flat_nq;
    logic [48:0]         nq_sum;
    logic signed [47:0]  nq, nq_sat;
    logic                pneg, dneg;
    logic [39:0]         pm, dm;
    logic [47:0]         cq;
    t_out_item           out_item;

    ppt_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range   = (32'(i_in.account) < ACCOUNTS) && (32'(i_in.symbol) < SYMBOLS);
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);

    assign fq      = r_in.fill_quantity;
    assign af      = f_mag48(fq);
    assign ao      = f_mag48(r_q);
    assign old_neg = r_q[47];
    assign old_pos = !r_q[47] && (r_q != '0);
    assign fq_neg  = fq[47];
    assign fq_pos  = !fq[47] && (fq != '0);
    assign flat_old = ao < {32'h0, r_eps};

    assign nq_sum  = {r_q[47], r_q} + {fq[47], fq};
    assign nq      = nq_sum[47:0];
    assign flat_nq = f_mag48(nq) < {32'h0, r_eps};
    assign nq_sat  = (nq_sum[48] != nq_sum[47]) ? (nq_sum[48] ? S48_MIN : S48_MAX) : nq;

    assign pneg = old_pos ? (r_in.price < r_avg) : (r_avg < r_in.price);
    assign pm   = (r_in.price > r_avg) ? (r_in.price - r_avg) : (r_avg - r_in.price);
    assign cq   = (af < ao) ? af : ao;
    assign dneg = r_mkt < r_avg;
    assign dm   = dneg ? (r_avg - r_mkt) : (r_mkt - r_avg);

    assign uses_mdu = (r_state == ST_AVG_MUL1) || (r_state == ST_AVG_MUL2) ||
                      (r_state == ST_AVG_DIV)  || (r_state == ST_RPNL_MUL) ||
                      (r_state == ST_COST_MUL) || (r_state == ST_UNR_MUL)  ||
                      (r_state == ST_MV_MUL)   || (r_state == ST_CB_MUL);

    assign mem_addr   = (r_state == ST_CLEAR) ? r_clr_cnt[IDX_W-1:0] : r_idx;
    assign cash_waddr = (r_state == ST_IDLE) ? ACCT_W'(i_in.account) : r_acct;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_W'(ENTRIES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    if (!in_range || i_in.func == FN_CASH) n_state = ST_OUT;
                    else n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: begin
                if (r_in.func == FN_FILL) n_state = ST_FILL;
                else if (r_in.func == FN_PRICE && r_rdata.valid) n_state = ST_UNR_MUL;
                else n_state = ST_OUT;
            end
            ST_FILL: begin
                if (flat_old) n_state = ST_COST_MUL;
                else if ((old_pos && fq_pos) || (old_neg && fq_neg)) n_state = ST_AVG_MUL1;
                else n_state = ST_RPNL_MUL;
            end
            ST_AVG_MUL1: if (mdu_rsp.done) n_state = ST_AVG_MUL2;
            ST_AVG_MUL2: if (mdu_rsp.done) n_state = ST_AVG_DIV;
            ST_AVG_DIV:  if (mdu_rsp.done) n_state = ST_COST_MUL;
            ST_RPNL_MUL: if (mdu_rsp.done) n_state = ST_RPNL_ADD;
            ST_RPNL_ADD: n_state = ST_COST_MUL;
            ST_COST_MUL: if (mdu_rsp.done) n_state = ST_DEBIT;
            ST_DEBIT:    n_state = ST_CASH;
            ST_CASH:     n_state = ST_UNR_MUL;
            ST_UNR_MUL:  if (mdu_rsp.done) n_state = ST_MV_MUL;
            ST_MV_MUL:   if (mdu_rsp.done) n_state = ST_CB_MUL;
            ST_CB_MUL:   if (mdu_rsp.done) n_state = ST_WRITE;
            ST_WRITE:    n_state = ST_OUT;
            ST_OUT:      if (out_load) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_in       = r_in;
        n_idx      = r_idx;
        n_acct     = r_acct;
        n_blank    = r_blank;
        n_kind     = r_kind;
        n_q        = r_q;
        n_avg      = r_avg;
        n_mkt      = r_mkt;
        n_pnl      = r_pnl;
        n_cash     = r_cash;
        n_acc      = r_acc;
        n_cost     = r_cost;
        n_unr      = r_unr;
        n_tot      = r_tot;
        n_mv       = r_mv;
        n_cb       = r_cb;
        mem_we     = 1'b0;
        mem_wdata  = '0;
        cash_we    = 1'b0;
        cash_wdata = '0;
        mdu_req    = '0;
        mdu_req.op = MDU_MUL;
        mdu_req.start = uses_mdu && !r_launched;
        n_launched = mdu_rsp.done ? 1'b0 : (r_launched || mdu_req.start);

        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_in    = i_in;
                    n_idx   = IDX_W'(32'(i_in.account) * 32'(SYMBOLS) + 32'(i_in.symbol));
                    n_acct  = ACCT_W'(i_in.account);
                    n_blank = 1'b1;
                    n_kind  = EV_ABSENT;
                    n_cash  = '0;
                    if (in_range && i_in.func == FN_CASH) begin
                        n_kind     = EV_CASH_SET;
                        n_cash     = i_in.cash_value;
                        cash_we    = 1'b1;
                        cash_wdata = i_in.cash_value;
                    end
                end
            end
            ST_LOAD: begin
                n_cash = r_cash_tab[r_acct];
                if (r_rdata.valid) begin
                    n_q   = r_rdata.qty;
                    n_avg = r_rdata.avg;
                    n_mkt = r_rdata.mkt;
                    n_pnl = r_rdata.pnl;
                end else begin
                    n_q   = '0;
                    n_avg = '0;
                    n_mkt = '0;
                    n_pnl = '0;
                end
                if (r_in.func == FN_FILL) begin
                    n_blank = 1'b0;
                end else if (r_in.func == FN_PRICE && r_rdata.valid) begin
                    n_blank = 1'b0;
                    n_kind  = EV_PRICE;
                    n_mkt   = r_in.price;
                end
            end
            ST_FILL: begin
                if (flat_old) begin
                    // drop any residual flat quantity
                    n_q    = fq;
                    n_avg  = r_in.price;
                    n_kind = EV_OPENED;
                end else if ((old_pos && fq_pos) || (old_neg && fq_neg)) begin
                    n_kind = EV_INCREASED;
                end
            end
            ST_AVG_MUL1: begin
                mdu_req.a = NUM_W'(r_avg);
                mdu_req.b = DEN_W'(ao);
                if (mdu_rsp.done) n_acc = mdu_rsp.res;
            end
            ST_AVG_MUL2: begin
                mdu_req.a = NUM_W'(r_in.price);
                mdu_req.b = DEN_W'(af);
                if (mdu_rsp.done) n_acc = r_acc + mdu_rsp.res;
            end
            ST_AVG_DIV: begin
                mdu_req.op = MDU_DIV;
                mdu_req.a  = r_acc;
                mdu_req.b  = DEN_W'(ao) + DEN_W'(af);
                if (mdu_rsp.done) begin
                    n_avg = mdu_rsp.res[39:0];
                    n_q   = nq_sat;
                end
            end
            ST_RPNL_MUL: begin
                mdu_req.a = NUM_W'(pm);
                mdu_req.b = DEN_W'(cq);
                if (mdu_rsp.done) n_cost = f_qmul(pneg, mdu_rsp.res[87:0]);
            end
            ST_RPNL_ADD: begin
                n_pnl = f_sat_add(r_pnl, r_cost);
                n_q   = nq;
                if (flat_nq) begin
                    n_kind = EV_CLOSED;
                end else if ((old_pos && nq[47]) || (old_neg && !nq[47] && nq != '0)) begin
                    n_kind = EV_REVERSED;
                    n_avg  = r_in.price;
                end else begin
                    n_kind = EV_DECREASED;
                end
            end
            ST_COST_MUL: begin
                mdu_req.a = NUM_W'(r_in.price);
                mdu_req.b = DEN_W'(af);
                if (mdu_rsp.done) n_cost = f_qmul(fq_neg, mdu_rsp.res[87:0]);
            end
            ST_DEBIT: begin
                n_cost = f_sat_add(r_cost, 64'(r_in.commission));
            end
            ST_CASH: begin
                n_cash     = f_sat_sub(r_cash, r_cost);
                cash_we    = 1'b1;
                cash_wdata = f_sat_sub(r_cash, r_cost);
            end
            ST_UNR_MUL: begin
                mdu_req.a = NUM_W'(dm);
                mdu_req.b = DEN_W'(ao);
                if (mdu_rsp.done) begin
                    n_unr = flat_old ? '0 : f_qmul(dneg ^ r_q[47], mdu_rsp.res[87:0]);
                end
            end
            ST_MV_MUL: begin
                mdu_req.a = NUM_W'(r_mkt);
                mdu_req.b = DEN_W'(ao);
                if (mdu_rsp.done) n_mv = 63'(f_qmul(1'b0, mdu_rsp.res[87:0]));
            end
            ST_CB_MUL: begin
                mdu_req.a = NUM_W'(r_avg);
                mdu_req.b = DEN_W'(ao);
                if (mdu_rsp.done) n_cb = 63'(f_qmul(1'b0, mdu_rsp.res[87:0]));
            end
            ST_WRITE: begin
                n_tot           = f_sat_add(r_pnl, r_unr);
                mem_we          = 1'b1;
                mem_wdata.valid = 1'b1;
                mem_wdata.qty   = r_q;
                mem_wdata.avg   = r_avg;
                mem_wdata.mkt   = r_mkt;
                mem_wdata.pnl   = r_pnl;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_item            = '0;
        out_item.event_kind = r_kind;
        out_item.cash_after = r_cash;
        if (!r_blank) begin
            out_item.position_size = r_q;
            out_item.entry_price   = r_avg;
            out_item.unrealized    = r_unr;
            out_item.realized      = r_pnl;
            out_item.total_profit  = r_tot;
            out_item.mkt_value     = r_mv;
            out_item.basis_value   = r_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACCOUNTS; i++) r_cash_tab[i] <= '0;
        end else if (cash_we) begin
            r_cash_tab[cash_waddr] <= cash_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_eps       <= EPS_RESET;
            r_launched  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_launched <= n_launched;
            if (r_state == ST_CLEAR) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cfg_we) r_eps <= i_cfg_wdata;
            if (out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
        if (out_load) r_out <= out_item;
        r_in    <= n_in;
        r_idx   <= n_idx;
        r_acct  <= n_acct;
        r_blank <= n_blank;
        r_kind  <= n_kind;
        r_q     <= n_q;
        r_avg   <= n_avg;
        r_mkt   <= n_mkt;
        r_pnl   <= n_pnl;
        r_cash  <= n_cash;
        r_acc   <= n_acc;
        r_cost  <= n_cost;
        r_unr   <= n_unr;
        r_tot   <= n_tot;
        r_mv    <= n_mv;
        r_cb    <= n_cb;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ===== dv/ppt_scoreboard.sv =====
// Prediction and comparison of the position and P&L tracker's result transactions.
`timescale 1ns / 100ps
module ppt_scoreboard
    import ppt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire t_in_item   i_in,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_out_item  i_out,
    output int              o_fail_count,
    output int              o_pending
);

    logic               pos_valid [4096];
    logic signed [47:0] pos_qty   [4096];
    logic [39:0]        pos_avg   [4096];
    logic [39:0]        pos_mkt   [4096];
    logic signed [63:0] pos_pnl   [4096];
    logic signed [63:0] acct_cash [16];
    logic [15:0]        flat_eps;
    t_out_item          expected_results [$];

    assign o_pending = expected_results.size();

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // floor(+/- a*b / 2^16), clamped to signed 64 bits
    function automatic logic signed [63:0] fixed_mul(input bit neg, input logic [63:0] a,
                                                     input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if (neg) p = p + 128'hFFFF;
        p = p >> 16;
        if (!neg) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : p[63:0];
        return (p >= 128'h8000_0000_0000_0000) ? S64_MIN : -p[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s > S64_MAX) return S64_MAX;
        if (s < S64_MIN) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_sub(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a - b;
        if (s > S64_MAX) return S64_MAX;
        if (s < S64_MIN) return S64_MIN;
        return s[63:0];
    endfunction

    function automatic bit is_flat(input logic signed [63:0] q);
        return magnitude(q) < {48'd0, flat_eps};
    endfunction

    function automatic t_out_item blank_result(input logic [2:0] kind,
                                               input logic signed [63:0] cash);
        t_out_item r;
        r = '0;
        r.event_kind = kind;
        r.cash_after = cash;
        return r;
    endfunction

    function automatic t_out_item position_result(input int e, input logic [2:0] kind,
                                                  input logic signed [63:0] cash);
        t_out_item          r;
        logic signed [63:0] q, unr;
        logic [63:0]        aq, dm;
        bit                 dneg;
        q   = pos_qty[e];
        aq  = magnitude(q);
        unr = 0;
        if (!is_flat(q)) begin
            dneg = pos_mkt[e] < pos_avg[e];
            dm   = dneg ? 64'(pos_avg[e] - pos_mkt[e]) : 64'(pos_mkt[e] - pos_avg[e]);
            unr  = fixed_mul(dneg != (q < 0), dm, aq);
        end
        r.event_kind    = kind;
        r.position_size = pos_qty[e];
        r.entry_price   = pos_avg[e];
        r.unrealized    = unr;
        r.realized      = pos_pnl[e];
        r.total_profit  = clamp_add(pos_pnl[e], unr);
        r.mkt_value     = 63'(fixed_mul(0, 64'(pos_mkt[e]), aq));
        r.basis_value   = 63'(fixed_mul(0, 64'(pos_avg[e]), aq));
        r.cash_after    = cash;
        return r;
    endfunction

    // Account and symbol fields are exactly as wide as the table, so no index is out of range.
    function automatic t_out_item apply_transaction(input t_in_item it);
        int                 e;
        logic [2:0]         kind;
        logic signed [63:0] old, fq, nq, cost, debit;
        logic [63:0]        ao, af, cq, pm;
        logic [127:0]       tot;
        logic [39:0]        avg;
        bit                 pneg;
        e = int'({it.account, it.symbol});
        if (it.func == FN_CASH) begin
            acct_cash[it.account] = it.cash_value;
            return blank_result(EV_CASH_SET, it.cash_value);
        end
        if (it.func == FN_PRICE) begin
            if (!pos_valid[e]) return blank_result(EV_ABSENT, acct_cash[it.account]);
            pos_mkt[e] = it.price;
            return position_result(e, EV_PRICE, acct_cash[it.account]);
        end
        if (it.func != FN_FILL) return blank_result(EV_ABSENT, acct_cash[it.account]);

        if (!pos_valid[e]) begin
            pos_valid[e] = 1'b1;
            pos_qty[e]   = '0;
            pos_avg[e]   = '0;
            pos_mkt[e]   = '0;
            pos_pnl[e]   = '0;
        end
        old = pos_qty[e];
        fq  = it.fill_quantity;
        ao  = magnitude(old);
        af  = magnitude(fq);
        if (is_flat(old)) begin
            pos_qty[e] = it.fill_quantity;
            pos_avg[e] = it.price;
            kind       = EV_OPENED;
        end else if ((old > 0 && fq > 0) || (old < 0 && fq < 0)) begin
            tot = {88'd0, pos_avg[e]} * {64'd0, ao} + {88'd0, it.price} * {64'd0, af};
            tot = tot / {64'd0, ao + af};
            pos_avg[e] = tot[39:0];
            nq = old + fq;
            if (nq > S48_MAX) nq = S48_MAX;
            if (nq < S48_MIN) nq = S48_MIN;
            pos_qty[e] = nq[47:0];
            kind       = EV_INCREASED;
        end else begin
            cq   = af < ao ? af : ao;
            avg  = pos_avg[e];
            pneg = (old > 0) ? (it.price < avg) : (avg < it.price);
            pm   = it.price > avg ? 64'(it.price - avg) : 64'(avg - it.price);
            pos_pnl[e] = clamp_add(pos_pnl[e], fixed_mul(pneg, pm, cq));
            nq = old + fq;
            pos_qty[e] = nq[47:0];
            if (is_flat(nq)) begin
                kind = EV_CLOSED;
            end else if ((old > 0 && nq < 0) || (old < 0 && nq > 0)) begin
                pos_avg[e] = it.price;
                kind       = EV_REVERSED;
            end else begin
                kind = EV_DECREASED;
            end
        end
        cost  = fixed_mul(fq < 0, af, 64'(it.price));
        debit = clamp_add(cost, 64'(it.commission));
        acct_cash[it.account] = clamp_sub(acct_cash[it.account], debit);
        return position_result(e, kind, acct_cash[it.account]);
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic compare_result(input t_out_item act);
        t_out_item exp_r;
        if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected: %h", act);
            o_fail_count++;
            return;
        end
        exp_r = expected_results.pop_front();
        check_field("event_kind", 64'(exp_r.event_kind), 64'(act.event_kind));
        check_field("position_size", 64'(exp_r.position_size), 64'(act.position_size));
        check_field("entry_price", 64'(exp_r.entry_price), 64'(act.entry_price));
        check_field("unrealized", exp_r.unrealized, act.unrealized);
        check_field("realized", exp_r.realized, act.realized);
        check_field("total_profit", exp_r.total_profit, act.total_profit);
        check_field("mkt_value", 64'(exp_r.mkt_value), 64'(act.mkt_value));
        check_field("basis_value", 64'(exp_r.basis_value), 64'(act.basis_value));
        check_field("cash_after", exp_r.cash_after, act.cash_after);
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4096; k++) pos_valid[k] = 1'b0;
            for (int k = 0; k < 16; k++) acct_cash[k] = '0;
            flat_eps = EPS_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) flat_eps = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                expected_results.insert(expected_results.size(), apply_transaction(i_in));
            if (i_out_valid && !i_out_stall) compare_result(i_out);
        end
    end

endmodule

// ===== dv/tb_position_pnl_tracker_top.sv =====
// Stimulus, handshake pacing and verdict for the position and P&L tracker.
`timescale 1ns / 100ps
module tb_position_pnl_tracker_top;
    import ppt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out;
    int          fail_count;
    int          pending;

    logic signed [63:0] net_qty [32];
    int                 burst_left;
    int                 rx_cycle;
    int                 rx_mode_left;
    int                 rx_mode;

    always #5 i_clk = ~i_clk;

    position_pnl_tracker_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    ppt_scoreboard scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic t_in_item make_txn(input logic [1:0] func, input logic [3:0] acct,
                                          input logic [7:0] sym,
                                          input logic signed [47:0] qty,
                                          input logic [39:0] price,
                                          input logic [39:0] comm,
                                          input logic signed [63:0] cash);
        t_in_item t;
        t.func          = func;
        t.account       = acct;
        t.symbol        = sym;
        t.fill_quantity = qty;
        t.price         = price;
        t.commission    = comm;
        t.cash_value    = cash;
        return t;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_txn(input t_in_item t);
        i_in       <= t;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_and_configure(input logic [15:0] eps);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= eps;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed traffic on a small pool of positions, with some full-range noise.
    function automatic t_in_item random_txn();
        t_in_item           t;
        int                 slot, pick;
        logic signed [63:0] q;
        slot = $urandom_range(0, 31);
        pick = $urandom_range(0, 99);
        t = make_txn(FN_FILL, 4'(slot >> 3), 8'(slot & 7), '0, '0, '0, '0);
        case ($urandom_range(0, 3))
            0: t.price = 40'(rand64());
            1: t.price = 40'($urandom_range(0, 65535));
            default: t.price = {8'd0, 16'($urandom_range(1, 5000)), 16'($urandom)};
        endcase
        t.commission = ($urandom_range(0, 9) == 0) ? 40'(rand64())
                                                   : 40'($urandom_range(0, 1 << 20));
        t.cash_value = ($urandom_range(0, 1) == 0) ? rand64() : 64'(signed'($urandom) <<< 16);
        case ($urandom_range(0, 4))
            0: q = signed'(48'(rand64()));
            1: q = $urandom_range(0, 20);
            default: q = {32'd0, 16'($urandom_range(1, 2000)), 16'($urandom)};
        endcase
        if ($urandom_range(0, 1) && $urandom_range(0, 4) != 1) q = -q;
        if (pick < 15) q = -net_qty[slot];
        t.fill_quantity = q[47:0];
        if (pick >= 60 && pick < 80) t.func = FN_PRICE;
        else if (pick >= 80 && pick < 88) t.func = FN_CASH;
        else if (pick >= 88 && pick < 92) t.func = FN_UNUSED;
        else if (pick >= 92) begin
            t.account = 4'($urandom);
            t.symbol  = 8'($urandom);
        end
        if (t.func == FN_FILL && t.account == 4'(slot >> 3) && t.symbol == 8'(slot & 7))
            net_qty[slot] = 64'(signed'(t.fill_quantity)) + net_qty[slot];
        return t;
    endfunction

    // Receiver: changing stall patterns, plus one long hold-off that backs up the input.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(50, 300);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        if (rx_cycle >= 30000 && rx_cycle < 30400) i_out_stall <= 1'b1;
        else if (rx_mode == 0) i_out_stall <= 1'b0;
        else if (rx_mode == 1) i_out_stall <= ($urandom_range(0, 9) < 3);
        else i_out_stall <= ($urandom_range(0, 9) < 7);
    end

    initial begin
        rx_cycle     = 0;
        rx_mode      = 0;
        rx_mode_left = 0;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [15:0] eps_list [5];
        int          gap;
        for (int k = 0; k < 32; k++) net_qty[k] = '0;
        eps_list[0] = 16'd7;
        eps_list[1] = 16'd0;
        eps_list[2] = 16'hFFFF;
        eps_list[3] = 16'($urandom);
        eps_list[4] = 16'd7;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_stall <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain_and_configure(eps_list[0]);

        // Directed: every event kind, zero fills, cash extremes, unused code, size extremes.
        send_txn(make_txn(FN_PRICE, 4'd5, 8'd3, '0, 40'd100 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, 48'sd10 <<< 16, 40'd100 << 16, 40'd5, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, 48'sd5 <<< 16, 40'd110 << 16, 40'd5, '0));
        send_txn(make_txn(FN_PRICE, 4'd5, 8'd3, '0, 40'd120 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, -(48'sd3 <<< 16), 40'd130 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, '0, 40'd130 << 16, 40'd1, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, -(48'sd12 <<< 16), 40'd90 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, -(48'sd4 <<< 16), 40'd95 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd3, 48'sd10 <<< 16, 40'd80 << 16, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd5, 8'd4, '0, 40'd1, '0, '0));
        send_txn(make_txn(FN_CASH, 4'd6, 8'd0, '0, '0, '0, S64_MAX));
        send_txn(make_txn(FN_FILL, 4'd6, 8'd0, -(48'sd3), 40'd7, '1, S64_MIN));
        send_txn(make_txn(FN_CASH, 4'd7, 8'hFF, '1, '1, '1, S64_MIN));
        send_txn(make_txn(FN_FILL, 4'd7, 8'hFF, S48_MAX, '1, '1, '0));
        send_txn(make_txn(FN_UNUSED, 4'd7, 8'hFF, S48_MAX, '1, '1, S64_MAX));
        send_txn(make_txn(FN_FILL, 4'd15, 8'd255, S48_MAX, '1, '1, '0));
        send_txn(make_txn(FN_FILL, 4'd15, 8'd255, S48_MAX, 40'd1, '0, '0));
        send_txn(make_txn(FN_PRICE, 4'd15, 8'd255, '0, '0, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd15, 8'd255, S48_MIN, '1, '1, '0));
        send_txn(make_txn(FN_FILL, 4'd0, 8'd200, S48_MIN, '1, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd0, 8'd200, S48_MIN, '0, '1, '0));
        send_txn(make_txn(FN_PRICE, 4'd0, 8'd200, '0, '1, '0, '0));
        send_txn(make_txn(FN_FILL, 4'd0, 8'd200, S48_MAX, 40'd3, '0, '0));

        burst_left = 0;
        for (int ph = 1; ph < 5; ph++) begin
            drain_and_configure(eps_list[ph]);
            for (int n = 0; n < 310; n++) begin
                if (burst_left == 0) begin
                    gap = $urandom_range(0, 20);
                    if (gap > 0) begin
                        i_in_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
                burst_left--;
                send_txn(random_txn());
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/ppt_pkg.sv
src/ppt_mdu.sv
src/position_pnl_tracker_top.sv
dv/ppt_scoreboard.sv
dv/tb_position_pnl_tracker_top.sv
